### rtl/ttsw_pkg.sv
// ----------------------------------------------------------------------------
// Texture tile swizzler package
// Shared constants, widths and format codes for the tiling pipeline.
// ----------------------------------------------------------------------------
package ttsw_pkg;

  // Default coordinate limits (clamp at MAX-1)
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;

  // Field widths
  localparam int unsigned CoordW  = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TprW    = 9;
  localparam int unsigned OffW    = 22;
  localparam int unsigned DataW   = 16;
  localparam int unsigned InDataW  = 56;  // 52 bits of fields, byte padded
  localparam int unsigned OutDataW = 40;  // 38 bits of fields, byte padded

  // Tiled layout formats
  typedef enum logic [1:0] {
    FMT_I8     = 2'd0,
    FMT_IA8    = 2'd1,
    FMT_RGB565 = 2'd2,
    FMT_RGBA8  = 2'd3
  } fmt_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_FORMAT = 1'b0,
    CFG_TPR    = 1'b1
  } cfg_idx_e;

  // Distance from the alpha-red word to the green-blue word in RGBA8
  localparam logic [OffW-1:0] Rgba8GbOff = 22'd32;

endpackage

### rtl/texture_tile_swizzler.sv
// ----------------------------------------------------------------------------
// Texture tile swizzler
// Maps a source pixel to its byte offset and data in a tiled texture.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle for I8, IA8 and RGB565 when the output is
// not stalled; RGBA8 pixels give two output transactions and hold the output
// stage until both are taken. Three register stages (input/clamp, tile-row
// multiply, offset sum) with valid bits; reset clears valids and sets format I8, one tile per row.
module texture_tile_swizzler #(
  parameter int unsigned MAX_WIDTH  = ttsw_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = ttsw_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ttsw_pkg::TprW-1:0]     cfg_data_i,
  // pixel input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel_column, pixel_row, byte_zero, byte_one, byte_two, byte_three, pad
  input  logic [ttsw_pkg::InDataW-1:0]  s_axis_tdata,
  // tiled output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // byte_offset, out_data, pad
  output logic [ttsw_pkg::OutDataW-1:0] m_axis_tdata,
  // is_single_byte
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int unsigned CW  = ttsw_pkg::CoordW;
  localparam int unsigned BW  = ttsw_pkg::ByteW;
  localparam int unsigned OW  = ttsw_pkg::OffW;
  localparam int unsigned DW  = ttsw_pkg::DataW;
  localparam int unsigned TW  = ttsw_pkg::TprW;
  localparam int unsigned PW  = CW - 2 + TW;   // tile row x tiles per row
  localparam int unsigned LW  = CW - 2 + 6;    // in-row linear offset
  localparam logic [31:0] COL_MAX = 32'(MAX_WIDTH - 1);
  localparam logic [31:0] ROW_MAX = 32'(MAX_HEIGHT - 1);

  // configuration
  ttsw_pkg::fmt_e format_q;
  logic [TW-1:0]  tpr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= ttsw_pkg::FMT_I8;
      tpr_q    <= TW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ttsw_pkg::CFG_FORMAT: format_q <= ttsw_pkg::fmt_e'(cfg_data_i[1:0]);
        ttsw_pkg::CFG_TPR:    tpr_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake chain
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_free;
  logic s3_last;

  assign s3_free       = !s3_valid_q || (m_axis_tready && s3_last);
  assign s2_ready      = !s2_valid_q || s3_free;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;

  // ---------------- stage 1: capture and clamp ----------------
  logic [CW-1:0] col_in, row_in, col_c, row_c;
  logic [CW-1:0] s1_col_q, s1_row_q;
  logic [BW-1:0] s1_b0_q, s1_b1_q, s1_b2_q, s1_b3_q;

  assign col_in = s_axis_tdata[CW-1:0];
  assign row_in = s_axis_tdata[2*CW-1:CW];
  assign col_c  = (32'(col_in) > COL_MAX) ? COL_MAX[CW-1:0] : col_in;
  assign row_c  = (32'(row_in) > ROW_MAX) ? ROW_MAX[CW-1:0] : row_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid) begin
      s1_col_q <= col_c;
      s1_row_q <= row_c;
      s1_b0_q  <= s_axis_tdata[2*CW+BW-1:2*CW];
      s1_b1_q  <= s_axis_tdata[2*CW+2*BW-1:2*CW+BW];
      s1_b2_q  <= s_axis_tdata[2*CW+3*BW-1:2*CW+2*BW];
      s1_b3_q  <= s_axis_tdata[2*CW+4*BW-1:2*CW+3*BW];
    end
  end

  // ---------------- stage 2: tile row multiply, data packing ----------------
  logic [PW-1:0] prod_d;
  logic [LW-1:0] lin_d;
  logic [DW-1:0] data0_d, data1_d;
  logic          single_d, rgba_d;

  logic [PW-1:0] s2_prod_q;
  logic [LW-1:0] s2_lin_q;
  logic [DW-1:0] s2_data0_q, s2_data1_q;
  logic          s2_single_q, s2_rgba_q;

  assign prod_d = PW'(s1_row_q[CW-1:2]) * PW'(tpr_q);

  always_comb begin
    lin_d    = {1'b0, s1_col_q[CW-1:2], s1_row_q[1:0], s1_col_q[1:0], 1'b0};
    data0_d  = {s1_b0_q, s1_b1_q};
    data1_d  = {s1_b2_q, s1_b3_q};
    single_d = 1'b0;
    rgba_d   = 1'b0;
    case (format_q)
      ttsw_pkg::FMT_I8: begin
        lin_d    = {2'b00, s1_col_q[CW-1:3], s1_row_q[1:0], s1_col_q[2:0]};
        data0_d  = {{BW{1'b0}}, s1_b0_q};
        single_d = 1'b1;
      end
      ttsw_pkg::FMT_IA8: ;
      ttsw_pkg::FMT_RGB565: begin
        data0_d = {s1_b0_q[7:3], s1_b1_q[7:2], s1_b2_q[7:3]};
      end
      ttsw_pkg::FMT_RGBA8: begin
        // 64-byte tiles
        lin_d  = {s1_col_q[CW-1:2], 1'b0, s1_row_q[1:0], s1_col_q[1:0], 1'b0};
        rgba_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_prod_q   <= prod_d;
      s2_lin_q    <= lin_d;
      s2_data0_q  <= data0_d;
      s2_data1_q  <= data1_d;
      s2_single_q <= single_d;
      s2_rgba_q   <= rgba_d;
    end
  end

  // ---------------- stage 3: offset sum and output ----------------
  logic [OW:0]   prod_sh;
  logic [OW-1:0] off_d;

  logic [OW-1:0] s3_off_q;
  logic [DW-1:0] s3_data0_q, s3_data1_q;
  logic          s3_single_q, s3_rgba_q, s3_phase_q;

  // 32 bytes per tile for the halfword and I8 tiles, 64 for RGBA8
  assign prod_sh = s2_rgba_q ? (OW+1)'({s2_prod_q, 6'b0}) : (OW+1)'({s2_prod_q, 5'b0});
  assign off_d   = prod_sh[OW-1:0] + OW'(s2_lin_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s3_phase_q <= 1'b0;
    end else if (s3_free) begin
      s3_valid_q <= s2_valid_q;
      s3_phase_q <= 1'b0;
    end else if (m_axis_tready) begin
      s3_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free) begin
      if (s2_valid_q) begin
        s3_off_q    <= off_d;
        s3_data0_q  <= s2_data0_q;
        s3_data1_q  <= s2_data1_q;
        s3_single_q <= s2_single_q;
        s3_rgba_q   <= s2_rgba_q;
      end
    end else if (m_axis_tready) begin
      // alpha-red sent, move to green-blue word
      s3_off_q   <= s3_off_q + ttsw_pkg::Rgba8GbOff;
      s3_data0_q <= s3_data1_q;
    end
  end

  assign s3_last       = !s3_rgba_q || s3_phase_q;
  assign m_axis_tvalid = s3_valid_q;
  assign m_axis_tdata  = {2'b00, s3_data0_q, s3_off_q};
  assign m_axis_tuser  = s3_single_q;
  assign m_axis_tlast  = s3_last;

  // ---------------- assertions ----------------
  a_rgba_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && s3_rgba_q && !s3_phase_q && m_axis_tready)
      |=> (s3_valid_q && s3_phase_q))
    else $error("RGBA8 second word not presented");

  a_rgba_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s3_phase_q) |-> (s3_off_q == $past(s3_off_q) + ttsw_pkg::Rgba8GbOff))
    else $error("RGBA8 green-blue offset not 32 bytes on");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && !s3_rgba_q))
    else $error("single byte transaction not last of pixel");

  a_phase_rgba: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_phase_q |-> (s3_valid_q && s3_rgba_q))
    else $error("second phase outside RGBA8 pixel");

endmodule
